[rtl/fss_pkg.sv]
// Shared types, codes and constants for the FAT32 file sector sequencer.
// No dependencies; imported by every module of the block.
package fss_pkg;

  // Sector geometry (fixed by the card interface)
  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int VB_W         = $clog2(SECTOR_BYTES + 1);
  localparam int OFF_W        = SECTOR_SHIFT;

  // Field widths
  localparam int CLUSTER_W = 28;
  localparam int WORD_W    = 32;
  localparam int SPC_W     = 8;
  localparam int BYTES_W   = 33;

  // Stream packing
  localparam int IN_DATA_W   = 64;
  localparam int IN_USER_W   = 2;
  localparam int OUT_PAY_W   = WORD_W + VB_W + OFF_W;
  localparam int OUT_DATA_W  = ((OUT_PAY_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 3;
  localparam int CFG_INDEX_W = 2;

  // Last cluster number that still points at a real cluster
  localparam logic [CLUSTER_W-1:0] CHAIN_LAST_OK = 28'hFFF_FFF6;

  // Request kinds
  typedef enum logic [IN_USER_W-1:0] {
    REQ_OPEN  = 2'd0,
    REQ_NEXT  = 2'd1,
    REQ_REPLY = 2'd2
  } req_t;

  // Result codes
  typedef enum logic [OUT_USER_W-1:0] {
    ST_OPENED    = 3'd0,
    ST_DATA      = 3'd1,
    ST_FAT       = 3'd2,
    ST_EOF       = 3'd3,
    ST_CHAIN_END = 3'd4,
    ST_BAD_ORDER = 3'd5
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPC       = 2'd0,
    CFG_FIRST_DAT = 2'd1,
    CFG_FAT_START = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [SPC_W-1:0]  sectors_per_cluster;
    logic [WORD_W-1:0] first_data_sector;
    logic [WORD_W-1:0] fat_start_sector;
  } cfg_t;

  // Walk state of the open file
  typedef struct packed {
    logic [CLUSTER_W-1:0] current_cluster;
    logic [WORD_W-1:0]    file_bytes;
    logic [BYTES_W-1:0]   bytes_given;
    logic [SPC_W-1:0]     sector_in_cluster;
    logic                 awaiting_fat;
  } walk_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] sector_address;
    logic [VB_W-1:0]   valid_bytes;
    logic [OFF_W-1:0]  fat_offset;
  } result_t;

endpackage

[rtl/fat32_file_sector_sequencer_top.sv]
// Top level of the FAT32 file sector sequencer: stream ports, config registers,
// input and result registers. Depends on fss_pkg and fss_step.
//
//  channel  | direction | handshake             | payload
//  s_axis   | in        | tvalid/tready         | tuser: req_type; tdata: cluster_word, file_length
//  m_axis   | out       | tvalid/tready         | tuser: status; tdata: sector_address,
//           |           |                       |        valid_bytes, fat_offset
//  cfg      | in        | we only, no wait      | index, data
//
// One request per cycle sustained while m_axis does not stall.
// Each request passes an input register, then the step logic (one 32x8 multiply-add)
// into the result register, where the walk state is updated in the same cycle.
// A stall on m_axis holds the result register, then the input register, then s_axis.
// Synchronous reset clears the walk state, config (sectors per cluster to 1) and valids.
module fat32_file_sector_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  // fields from bit 0: cluster_word[31:0], file_length[63:32]
  input  logic [fss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // fields from bit 0: req_type[1:0]
  input  logic [fss_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: sector_address[31:0], valid_bytes[41:32], fat_offset[50:42]
  output logic [fss_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // fields from bit 0: status[2:0]
  output logic [fss_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we,
  input  logic [fss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fss_pkg::WORD_W-1:0]        cfg_data
);
  import fss_pkg::*;

  cfg_t              cfg;
  walk_t             walk;
  walk_t             walk_next;
  result_t           step_res;
  result_t           out_res;
  logic              in_valid;
  logic [IN_USER_W-1:0] in_req;
  logic [WORD_W-1:0] in_word;
  logic [WORD_W-1:0] in_len;
  logic              out_ready;
  logic              advance;

  // Pipeline flow control
  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sectors_per_cluster <= SPC_W'(1);
      cfg.first_data_sector   <= '0;
      cfg.fat_start_sector    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPC:       cfg.sectors_per_cluster <= cfg_data[SPC_W-1:0];
        CFG_FIRST_DAT: cfg.first_data_sector   <= cfg_data;
        CFG_FAT_START: cfg.fat_start_sector    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req  <= s_axis_tuser;
      in_word <= s_axis_tdata[WORD_W-1:0];
      in_len  <= s_axis_tdata[2*WORD_W-1:WORD_W];
    end
  end

  fss_step u_step (
    .cfg          (cfg),
    .cur          (walk),
    .req_type     (in_req),
    .cluster_word (in_word),
    .file_length  (in_len),
    .nxt          (walk_next),
    .res          (step_res)
  );

  // Walk state advances as the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (advance) begin
      walk <= walk_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {{(OUT_DATA_W-OUT_PAY_W){1'b0}}, out_res.fat_offset,
                         out_res.valid_bytes, out_res.sector_address};

endmodule

[rtl/fss_step.sv]
// Next-state and result logic for one request of the sector sequencer.
// Pure combinational; depends on fss_pkg.
module fss_step (
  input  fss_pkg::cfg_t             cfg,
  input  fss_pkg::walk_t            cur,
  input  logic [1:0]                req_type,
  input  logic [31:0]               cluster_word,
  input  logic [31:0]               file_length,
  output fss_pkg::walk_t            nxt,
  output fss_pkg::result_t          res
);
  import fss_pkg::*;

  logic [CLUSTER_W-1:0]  masked_word;
  logic                  chain_end;
  logic                  is_reply;
  logic [CLUSTER_W-1:0]  data_cluster;
  logic [SPC_W-1:0]      data_sic;
  logic [WORD_W-1:0]     base;
  logic [WORD_W-1:0]     prod;
  logic [WORD_W-1:0]     data_sector;
  logic [BYTES_W-1:0]    left;
  logic [VB_W-1:0]       data_vb;
  logic [CLUSTER_W+1:0]  byte_pos;
  logic [WORD_W-1:0]     fat_sector;
  logic [OFF_W-1:0]      fat_off;
  walk_t                 data_nxt;
  result_t               data_res;

  assign masked_word = cluster_word[CLUSTER_W-1:0];
  assign chain_end   = (masked_word == '0) || (masked_word > CHAIN_LAST_OK);
  assign is_reply    = (req_type == REQ_REPLY);

  // A reply moves to sector 0 of the new cluster before the data sector is formed
  assign data_cluster = is_reply ? masked_word : cur.current_cluster;
  assign data_sic     = is_reply ? '0 : cur.sector_in_cluster;

  // Data sector: (cluster - 2) * spc + first data sector + sector in cluster
  assign base        = {{(WORD_W-CLUSTER_W){1'b0}}, data_cluster} - WORD_W'(2);
  assign prod        = base * {{(WORD_W-SPC_W){1'b0}}, cfg.sectors_per_cluster};
  assign data_sector = prod + cfg.first_data_sector
                     + {{(WORD_W-SPC_W){1'b0}}, data_sic};

  // Bytes of this sector that still belong to the file
  assign left    = {1'b0, cur.file_bytes} - cur.bytes_given;
  assign data_vb = (left < BYTES_W'(SECTOR_BYTES)) ? left[VB_W-1:0] : VB_W'(SECTOR_BYTES);

  // FAT entry position: four bytes per cluster
  assign byte_pos   = {cur.current_cluster, 2'b00};
  assign fat_off    = byte_pos[OFF_W-1:0];
  assign fat_sector = cfg.fat_start_sector + WORD_W'(byte_pos >> SECTOR_SHIFT);

  // Outcome of handing out a data sector
  always_comb begin
    data_nxt                   = cur;
    data_nxt.current_cluster   = data_cluster;
    data_nxt.sector_in_cluster = data_sic + SPC_W'(1);
    data_nxt.bytes_given       = cur.bytes_given + BYTES_W'(SECTOR_BYTES);
    data_nxt.awaiting_fat      = 1'b0;
    data_res.status            = ST_DATA;
    data_res.sector_address    = data_sector;
    data_res.valid_bytes       = data_vb;
    data_res.fat_offset        = '0;
  end

  // Request decode
  always_comb begin
    nxt                = cur;
    res.status         = ST_BAD_ORDER;
    res.sector_address = '0;
    res.valid_bytes    = '0;
    res.fat_offset     = '0;
    unique case (req_type)
      REQ_OPEN: begin
        nxt.current_cluster   = masked_word;
        nxt.file_bytes        = file_length;
        nxt.bytes_given       = '0;
        nxt.sector_in_cluster = '0;
        nxt.awaiting_fat      = 1'b0;
        res.status            = ST_OPENED;
      end
      REQ_NEXT: begin
        priority if (cur.awaiting_fat) begin
          res.status = ST_BAD_ORDER;
        end else if (cur.bytes_given >= {1'b0, cur.file_bytes}) begin
          res.status = ST_EOF;
        end else if (cur.sector_in_cluster >= cfg.sectors_per_cluster) begin
          nxt.awaiting_fat   = 1'b1;
          res.status         = ST_FAT;
          res.sector_address = fat_sector;
          res.fat_offset     = fat_off;
        end else begin
          nxt = data_nxt;
          res = data_res;
        end
      end
      REQ_REPLY: begin
        priority if (!cur.awaiting_fat) begin
          res.status = ST_BAD_ORDER;
        end else if (chain_end) begin
          nxt.awaiting_fat = 1'b0;
          res.status       = ST_CHAIN_END;
        end else begin
          nxt = data_nxt;
          res = data_res;
        end
      end
      default: begin
        res.status = ST_BAD_ORDER;
      end
    endcase
  end

endmodule

[rtl/fss_check.sv]
// Port-level checks on the result stream of the sector sequencer, bound to the top.
// Depends on fss_pkg and fat32_file_sector_sequencer_top.
module fss_check (
  input logic                           clk,
  input logic                           rst,
  input logic [fss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [fss_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import fss_pkg::*;

  localparam int VB_LO  = WORD_W;
  localparam int OFF_LO = WORD_W + VB_W;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A data sector carries between one byte and a full sector
  a_data_bytes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_DATA |->
      m_axis_tdata[OFF_LO-1:VB_LO] != '0 &&
      m_axis_tdata[OFF_LO-1:VB_LO] <= VB_W'(SECTOR_BYTES))
    else $error("data sector byte count out of range");

  // Only a FAT lookup carries an offset, only a data sector a byte count
  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser == ST_FAT || m_axis_tdata[OFF_LO+OFF_W-1:OFF_LO] == '0) &&
      (m_axis_tuser == ST_DATA || m_axis_tdata[OFF_LO-1:VB_LO] == '0))
    else $error("unused result field not zero");

endmodule

bind fat32_file_sector_sequencer_top fss_check u_fss_check (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

[verif/tb_fat32_file_sector_sequencer_top.sv]
// Self-checking testbench for fat32_file_sector_sequencer_top: walks FAT32 cluster chains,
// predicts every result and compares each m_axis transaction field by field.
// Depends on fss_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_fat32_file_sector_sequencer_top;
  import fss_pkg::*;

  localparam int          LIMIT_CYCLES = 500000;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  // One predicted result
  typedef struct {
    status_t     st;
    logic [31:0] addr;
    logic [9:0]  vb;
    logic [8:0]  off;
  } sector_result_t;

  logic clk;
  logic rst = 1'b1;

  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [WORD_W-1:0]      cfg_data      = '0;

  fat32_file_sector_sequencer_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Predictor copy of the geometry registers
  logic [7:0]  geo_spc       = 8'd1;
  logic [31:0] geo_data_base = '0;
  logic [31:0] geo_fat_base  = '0;

  // Predictor copy of the walk state
  logic [27:0] walk_cluster  = '0;
  logic [31:0] walk_size     = '0;
  logic [32:0] walk_given    = '0;
  logic [7:0]  walk_sector   = '0;
  logic        walk_wait_fat = 1'b0;

  sector_result_t walk_results_q[$];

  int mismatches     = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t: mismatch in %s: expected %0h, got %0h", $time, field, exp_v, got_v);
    mismatches++;
  endtask

  // Hand out the next data sector of the current cluster
  function automatic sector_result_t next_data_sector();
    sector_result_t r;
    logic [31:0]    base;
    logic [63:0]    left;
    base   = {4'b0, walk_cluster} - 32'd2;
    r.st   = ST_DATA;
    r.addr = base * {24'b0, geo_spc} + geo_data_base + {24'b0, walk_sector};
    left   = {32'b0, walk_size} - {31'b0, walk_given};
    r.vb   = (left < 64'd512) ? left[9:0] : 10'd512;
    r.off  = '0;
    walk_given  = walk_given + 33'd512;
    walk_sector = walk_sector + 8'd1;
    return r;
  endfunction

  // Expected result of one request; updates the predicted walk state
  function automatic sector_result_t walk_step(input logic [1:0] kind,
                                               input logic [31:0] word,
                                               input logic [31:0] len);
    sector_result_t r;
    logic [27:0]    next_cl;
    r = '{st: ST_BAD_ORDER, addr: '0, vb: '0, off: '0};
    next_cl = word[27:0];
    case (kind)
      REQ_OPEN: begin
        walk_cluster  = word[27:0];
        walk_size     = len;
        walk_given    = '0;
        walk_sector   = '0;
        walk_wait_fat = 1'b0;
        r.st = ST_OPENED;
      end
      REQ_NEXT: begin
        if (walk_wait_fat) begin
          r.st = ST_BAD_ORDER;
        end else if (walk_given >= {1'b0, walk_size}) begin
          r.st = ST_EOF;
        end else if (walk_sector >= geo_spc) begin
          // FAT entry is 4 bytes: 128 entries per sector
          r.st   = ST_FAT;
          r.addr = geo_fat_base + {11'b0, walk_cluster[27:7]};
          r.off  = {walk_cluster[6:0], 2'b00};
          walk_wait_fat = 1'b1;
        end else begin
          r = next_data_sector();
        end
      end
      REQ_REPLY: begin
        if (walk_wait_fat) begin
          walk_wait_fat = 1'b0;
          if (next_cl == '0 || next_cl > CHAIN_LAST_OK) begin
            r.st = ST_CHAIN_END;
          end else begin
            walk_cluster = next_cl;
            walk_sector  = '0;
            r = next_data_sector();
          end
        end
      end
      default: r.st = ST_BAD_ORDER;
    endcase
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    sector_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (walk_results_q.size() == 0) begin
        report_mismatch("unexpected result, status", '0, {29'b0, m_axis_tuser});
      end else begin
        e = walk_results_q.pop_front();
        if (m_axis_tuser != e.st)
          report_mismatch("status", {29'b0, e.st}, {29'b0, m_axis_tuser});
        if (m_axis_tdata[31:0] != e.addr)
          report_mismatch("sector_address", e.addr, m_axis_tdata[31:0]);
        if (m_axis_tdata[41:32] != e.vb)
          report_mismatch("valid_bytes", {22'b0, e.vb}, {22'b0, m_axis_tdata[41:32]});
        if (m_axis_tdata[50:42] != e.off)
          report_mismatch("fat_offset", {23'b0, e.off}, {23'b0, m_axis_tdata[50:42]});
      end
    end
  end

  // Offer one request and wait for its transaction
  task automatic send_req(input logic [1:0] kind, input logic [31:0] word,
                          input logic [31:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {len, word};
    s_axis_tvalid <= 1'b1;
    walk_results_q.push_back(walk_step(kind, word, len));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every expected result, then the pipeline latency
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three geometry registers; only called while idle
  task automatic set_geometry(input logic [7:0] spc, input logic [31:0] data_base,
                              input logic [31:0] fat_base);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPC;
    cfg_data  <= {24'b0, spc};
    @(posedge clk);
    cfg_index <= CFG_FIRST_DAT;
    cfg_data  <= data_base;
    @(posedge clk);
    cfg_index <= CFG_FAT_START;
    cfg_data  <= fat_base;
    @(posedge clk);
    cfg_we <= 1'b0;
    geo_spc       = spc;
    geo_data_base = data_base;
    geo_fat_base  = fat_base;
  endtask

  // One request of a mostly well-formed walk, picked from the predicted state
  task automatic send_walk_item();
    int          r;
    logic [1:0]  kind;
    logic [31:0] word;
    logic [31:0] len;
    r    = $urandom_range(99);
    kind = REQ_NEXT;
    word = $urandom;
    len  = $urandom;
    if (walk_wait_fat && r < 85) begin
      kind = REQ_REPLY;
      if ($urandom_range(9) == 0) begin
        // chain end: masked zero or a reserved/last-cluster marker
        word[27:0] = $urandom_range(1) ? 28'h0 : 28'hFFFFFF7 + 28'($urandom_range(8));
      end else if ($urandom_range(1)) begin
        word[27:0] = 28'($urandom_range(5000, 2));
      end else begin
        word[27:0] = 28'($urandom_range(28'hFFFFFF6, 2));
      end
    end else if (r < 4) begin
      kind = 2'($urandom_range(3));
    end else if (r < 8 || (walk_given >= {1'b0, walk_size} && r < 60)) begin
      kind = REQ_OPEN;
      if ($urandom_range(3) != 0)
        word[27:0] = 28'($urandom_range(300));
      case ($urandom_range(9))
        0:       len = $urandom;
        1, 2:    len = $urandom_range(20000);
        default: len = $urandom_range(3000);
      endcase
    end
    send_req(kind, word, len);
  endtask

  task automatic run_walks(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_walk_item();
    drain_results();
  endtask

  // Directed: ordering errors, masking, chain ends, wrap-around and extremes
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(REQ_NEXT, 32'h0, 32'h0);              // nothing open: end of file
    send_req(REQ_REPLY, 32'h5, 32'h0);             // reply with no lookup pending
    send_req(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_OPEN, 32'hFFFF_FFF0, 32'd1000);   // start cluster masked
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_NEXT, 32'h0, 32'h0);              // lookup
    send_req(REQ_NEXT, 32'h0, 32'h0);              // still waiting for the reply
    send_req(REQ_REPLY, 32'hF000_0000, 32'h0);     // masked zero: chain end
    send_req(REQ_NEXT, 32'h0, 32'h0);              // same lookup again
    send_req(REQ_REPLY, 32'h0FFF_FFF7, 32'h0);     // first chain-end marker
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_REPLY, 32'hFFFF_FFF6, 32'h0);     // last good cluster
    send_req(REQ_NEXT, 32'h0, 32'h0);              // end of file
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_OPEN, 32'h0, 32'hFFFF_FFFF);      // cluster below two wraps
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_OPEN, 32'h1, 32'd512);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_OPEN, 32'h5, 32'd5000);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_NEXT, 32'h0, 32'h0);              // lookup, then dropped by open
    send_req(REQ_OPEN, 32'h3, 32'd1);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    drain_results();
    // zero sectors per cluster and both bases at their top
    set_geometry(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_OPEN, 32'h0FFF_FFFF, 32'd100);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    send_req(REQ_REPLY, 32'h2, 32'h0);
    send_req(REQ_NEXT, 32'h0, 32'h0);
    drain_results();
  endtask

  task automatic test_walk_no_idle();
    set_geometry(8'($urandom_range(8, 1)), $urandom, $urandom);
    run_walks(250, 0, 0);
  endtask

  task automatic test_walk_sender_idle();
    set_geometry(8'($urandom_range(4, 1)), $urandom, $urandom);
    run_walks(250, 80, 0);
  endtask

  task automatic test_walk_receiver_stall();
    set_geometry(8'($urandom_range(16, 1)), $urandom, $urandom);
    run_walks(250, 0, 80);
  endtask

  task automatic test_walk_both_idle();
    set_geometry(8'($urandom_range(2, 1)), $urandom, $urandom);
    run_walks(250, 29, 29);
  endtask

  // Extreme geometry settings
  task automatic test_geometry_extremes();
    set_geometry(8'd1, 32'h0, 32'h0);
    run_walks(200, 0, 0);
    set_geometry(8'd128, 32'hFFFF_FFFF, 32'h0);
    run_walks(200, 29, 29);
    set_geometry(8'd0, 32'h0, 32'hFFFF_FFFF);
    run_walks(200, 0, 29);
    set_geometry(8'd255, $urandom, $urandom);
    run_walks(200, 29, 0);
  endtask

  // Long receiver hold-off with the sender pushing, then a full pause mid-stream
  task automatic test_backpressure();
    set_geometry(8'($urandom_range(3, 1)), $urandom, $urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (60) send_walk_item();
    drain_results();
    repeat (40) send_walk_item();
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_walk_no_idle();
    test_walk_sender_idle();
    test_walk_receiver_stall();
    test_walk_both_idle();
    test_geometry_extremes();
    test_backpressure();
    drain_results();
    if (mismatches == 0 && walk_results_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
